// ===== src/vmph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vmph_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [30:0] AGE_INACTIVE = 31'h7FFF_FFFF;
  localparam logic [9:0]  LEVEL_CAP    = 10'd192;
  localparam logic [8:0]  PEAK_FALL    = 9'd2;
  localparam logic [7:0]  BLINK_FULL   = 8'd255;

  localparam logic [7:0] HOLD_TICKS_RST       = 8'd30;
  localparam logic [7:0] BLINK_DECAY_RST      = 8'd8;
  localparam logic [7:0] RECENT_AGE_LIMIT_RST = 8'd3;

  typedef enum logic [1:0] {
    REG_HOLD_TICKS       = 2'd0,
    REG_BLINK_DECAY      = 2'd1,
    REG_RECENT_AGE_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] hold_ticks;
    logic [7:0] blink_decay;
    logic [7:0] recent_age_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] peak;
    logic [7:0]        hold;
    logic [7:0]        timer;
    logic [7:0]        blink;
  } chan_state_t;

endpackage

`default_nettype wire

// ===== src/vmph_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vmph_update (
  input  vmph_pkg::cfg_t        cfg,
  input  logic [4:0]            channel,
  input  logic                  has_sample,
  input  logic                  period_nonzero,
  input  logic [7:0]            volume,
  input  logic [30:0]           age,
  input  vmph_pkg::chan_state_t st_cur,
  output vmph_pkg::chan_state_t st_next,
  output logic                  in_range
);
  import vmph_pkg::*;

  logic [9:0]        vol3;
  logic              active;
  logic [7:0]        level_u;
  logic signed [8:0] level_s;
  logic signed [8:0] pk;

  always_comb begin
    in_range = (int'(channel) < NUM_CHANNELS);
    vol3     = {2'b00, volume} + {1'b0, volume, 1'b0};
    active   = has_sample && period_nonzero && (volume != 8'd0) && (age != AGE_INACTIVE);
    if (!active) begin
      level_u = 8'd0;
    end else if (vol3 > LEVEL_CAP) begin
      level_u = LEVEL_CAP[7:0];
    end else begin
      level_u = vol3[7:0];
    end
    level_s = $signed({1'b0, level_u});

    // peak: jump up to the level, else fall while above zero (may reach -1)
    if (level_s > st_cur.peak) begin
      pk = level_s;
    end else if (st_cur.peak > 9'sd0) begin
      pk = st_cur.peak - $signed(PEAK_FALL);
    end else begin
      pk = st_cur.peak;
    end
    st_next.peak = pk;

    st_next.hold  = st_cur.hold;
    st_next.timer = st_cur.timer;
    if (pk > $signed({1'b0, st_cur.hold})) begin
      st_next.hold  = pk[7:0];
      st_next.timer = cfg.hold_ticks;
    end else if (st_cur.timer != 8'd0) begin
      st_next.timer = st_cur.timer - 8'd1;
    end else if (st_cur.hold != 8'd0) begin
      st_next.hold = st_cur.hold - 8'd1;
    end

    if (age < {23'd0, cfg.recent_age_limit}) begin
      st_next.blink = BLINK_FULL;
    end else if (st_cur.blink > cfg.blink_decay) begin
      st_next.blink = st_cur.blink - cfg.blink_decay;
    end else begin
      st_next.blink = 8'd0;
    end
  end

endmodule

`default_nettype wire

// ===== src/vu_meter_peak_hold.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-channel VU meter with peak hold and activity light. One request per clock
// is taken in sustained flow while the output is not stalled; a result passes
// through the input register, then the result register that is loaded in the
// same edge that writes the channel's state back. The per-channel peak, hold,
// hold timer and light brightness live in flip-flops that the synchronous reset
// clears at once, so a request for the same channel may follow in the next cycle.
// Configuration sits at byte addresses 0 (hold_ticks), 4 (blink_decay) and
// 8 (recent_age_limit), low 8 bits of the data; write only while idle.
module vu_meter_peak_hold (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[4:0], has_sample[5], period_nonzero[6], volume[14:7], age[45:15]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // channel_out[4:0], peak_level[13:5], hold_level[21:14], blink_level[29:22]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vmph_pkg::*;

  cfg_t cfg;

  logic        s1_valid;
  logic [4:0]  s1_channel;
  logic        s1_has_sample;
  logic        s1_period_nonzero;
  logic [7:0]  s1_volume;
  logic [30:0] s1_age;

  logic out_free;
  logic s1_adv;

  logic signed [8:0] peak_store       [NUM_CHANNELS];
  logic [7:0]        hold_store       [NUM_CHANNELS];
  logic [7:0]        hold_timer_store [NUM_CHANNELS];
  logic [7:0]        blink_store      [NUM_CHANNELS];

  logic [CH_IDX_W-1:0] idx;
  chan_state_t         st_cur;
  chan_state_t         st_next;
  logic                in_range;

  logic [4:0]  res_channel;
  logic [8:0]  res_peak;
  logic [7:0]  res_hold;
  logic [7:0]  res_blink;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks       <= HOLD_TICKS_RST;
      cfg.blink_decay      <= BLINK_DECAY_RST;
      cfg.recent_age_limit <= RECENT_AGE_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_HOLD_TICKS:       cfg.hold_ticks       <= pwdata[7:0];
        REG_BLINK_DECAY:      cfg.blink_decay      <= pwdata[7:0];
        REG_RECENT_AGE_LIMIT: cfg.recent_age_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HOLD_TICKS:       prdata = {24'd0, cfg.hold_ticks};
      REG_BLINK_DECAY:      prdata = {24'd0, cfg.blink_decay};
      REG_RECENT_AGE_LIMIT: prdata = {24'd0, cfg.recent_age_limit};
      default:              prdata = 32'd0;
    endcase
  end

  // flow control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_channel        <= s_axis_tdata[4:0];
      s1_has_sample     <= s_axis_tdata[5];
      s1_period_nonzero <= s_axis_tdata[6];
      s1_volume         <= s_axis_tdata[14:7];
      s1_age            <= s_axis_tdata[45:15];
    end
  end

  // channel state read
  assign idx = CH_IDX_W'(s1_channel);

  always_comb begin
    st_cur.peak  = peak_store[idx];
    st_cur.hold  = hold_store[idx];
    st_cur.timer = hold_timer_store[idx];
    st_cur.blink = blink_store[idx];
  end

  vmph_update u_update (
    .cfg            (cfg),
    .channel        (s1_channel),
    .has_sample     (s1_has_sample),
    .period_nonzero (s1_period_nonzero),
    .volume         (s1_volume),
    .age            (s1_age),
    .st_cur         (st_cur),
    .st_next        (st_next),
    .in_range       (in_range)
  );

  // state write-back, same edge as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        peak_store[i]       <= 9'sd0;
        hold_store[i]       <= 8'd0;
        hold_timer_store[i] <= 8'd0;
        blink_store[i]      <= 8'd0;
      end
    end else if (s1_adv && in_range) begin
      peak_store[idx]       <= st_next.peak;
      hold_store[idx]       <= st_next.hold;
      hold_timer_store[idx] <= st_next.timer;
      blink_store[idx]      <= st_next.blink;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_channel <= s1_channel;
      // a channel outside the meter bank reports zero levels
      if (in_range) begin
        res_peak  <= st_next.peak;
        res_hold  <= st_next.hold;
        res_blink <= st_next.blink;
      end else begin
        res_peak  <= 9'd0;
        res_hold  <= 8'd0;
        res_blink <= 8'd0;
      end
    end
  end

  assign m_axis_tdata = {2'b00, res_blink, res_hold, res_peak, res_channel};

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import vmph_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  // input request as it sits in s_axis_tdata, channel in the lowest bits
  typedef struct packed {
    logic [30:0] age;
    logic [7:0]  volume;
    logic        period_nonzero;
    logic        has_sample;
    logic [4:0]  channel;
  } tick_t;

  // result as it sits in m_axis_tdata[29:0]
  typedef struct packed {
    logic [7:0]        blink;
    logic [7:0]        hold;
    logic signed [8:0] peak;
    logic [4:0]        channel;
  } meter_t;

  typedef enum {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    tick_t      tick;
    bit         typed;
    meter_t     want;
    reg_idx_t   idx;
    logic [7:0] val;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // channel[4:0], has_sample[5], period_nonzero[6], volume[14:7], age[45:15]
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // channel_out[4:0], peak_level[13:5], hold_level[21:14], blink_level[29:22]
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vu_meter_peak_hold u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // predictor state, one entry per channel
  logic signed [8:0] peak_mem  [NUM_CHANNELS];
  logic [7:0]        hold_mem  [NUM_CHANNELS];
  logic [7:0]        timer_mem [NUM_CHANNELS];
  logic [7:0]        blink_mem [NUM_CHANNELS];
  cfg_t              meter_cfg;

  meter_t expected_meters[$];
  int     mismatches = 0;
  int     ticks_sent = 0;
  int     meters_seen = 0;
  int     reg_writes = 0;
  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;
  int     quiet_cycles = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic meter_t advance_meter(input tick_t t);
    meter_t m;
    int     lvl;
    int     pk;
    int     ch;
    m = '0;
    m.channel = t.channel;
    lvl = 0;
    ch = int'(t.channel);
    if (ch >= NUM_CHANNELS) return m;
    if (t.has_sample && t.period_nonzero && t.volume != 0 && t.age != AGE_INACTIVE) begin
      lvl = 3 * int'(t.volume);
      if (lvl > int'(LEVEL_CAP)) lvl = int'(LEVEL_CAP);
    end
    pk = int'(peak_mem[ch]);
    if (lvl > pk) begin
      pk = lvl;
    end else if (pk > 0) begin
      pk = pk - int'(PEAK_FALL);
    end
    peak_mem[ch] = pk[8:0];
    if (pk > int'(hold_mem[ch])) begin
      hold_mem[ch]  = pk[7:0];
      timer_mem[ch] = meter_cfg.hold_ticks;
    end else if (timer_mem[ch] != 0) begin
      timer_mem[ch]--;
    end else if (hold_mem[ch] != 0) begin
      hold_mem[ch]--;
    end
    if (t.age < 31'(meter_cfg.recent_age_limit)) begin
      blink_mem[ch] = BLINK_FULL;
    end else if (blink_mem[ch] > meter_cfg.blink_decay) begin
      blink_mem[ch] = blink_mem[ch] - meter_cfg.blink_decay;
    end else begin
      blink_mem[ch] = '0;
    end
    m.peak  = peak_mem[ch];
    m.hold  = hold_mem[ch];
    m.blink = blink_mem[ch];
    return m;
  endfunction

  function automatic plan_row_t tick_row(input logic [4:0] ch, input bit smp, input bit per,
                                         input logic [7:0] vol, input logic [30:0] age,
                                         input bit typed = 1'b0, input int pk = 0,
                                         input int hd = 0, input int bl = 0);
    plan_row_t r;
    r.kind  = ROW_TICK;
    r.tick  = '{age: age, volume: vol, period_nonzero: per, has_sample: smp, channel: ch};
    r.typed = typed;
    r.want  = '{blink: bl[7:0], hold: hd[7:0], peak: pk[8:0], channel: ch};
    r.idx   = REG_HOLD_TICKS;
    r.val   = '0;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input reg_idx_t idx, input logic [7:0] val);
    plan_row_t r;
    r = tick_row(5'd0, 1'b0, 1'b0, 8'd0, 31'd0);
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    // most requests hit a few channels so rise, fall and hold sequences build up
    t.channel = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    t.has_sample = ($urandom_range(99) < 85);
    t.period_nonzero = ($urandom_range(99) < 85);
    case ($urandom_range(9))
      0:       t.volume = 8'd0;
      1:       t.volume = 8'd255;
      2:       t.volume = 8'($urandom_range(1, 8));
      3:       t.volume = 8'($urandom_range(60, 70));
      default: t.volume = 8'($urandom_range(255));
    endcase
    case ($urandom_range(9))
      0:       t.age = AGE_INACTIVE;
      1:       t.age = AGE_INACTIVE - 31'd1;
      2:       t.age = 31'($urandom);
      3:       t.age = 31'($urandom_range(300));
      default: t.age = 31'($urandom_range(255));
    endcase
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input bit typed, input meter_t typed_want);
    meter_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t};
    do @(posedge clk); while (!s_axis_tready);
    want = advance_meter(t);
    if (typed) want = typed_want;
    expected_meters.push_back(want);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_meters.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HOLD_TICKS:       meter_cfg.hold_ticks = val;
      REG_BLINK_DECAY:      meter_cfg.blink_decay = val;
      REG_RECENT_AGE_LIMIT: meter_cfg.recent_age_limit = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // result checker; also drives the sink-side stall pattern
  always @(posedge clk) begin
    meter_t got;
    meter_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = meter_t'(m_axis_tdata[29:0]);
      meters_seen++;
      if (expected_meters.size() == 0) begin
        flag_mismatch("result with nothing pending", int'(got.channel), -1);
      end else begin
        want = expected_meters.pop_front();
        if (got.channel !== want.channel)
          flag_mismatch("channel_out", int'(got.channel), int'(want.channel));
        if (got.peak !== want.peak)
          flag_mismatch("peak_level", int'(got.peak), int'(want.peak));
        if (got.hold !== want.hold)
          flag_mismatch("hold_level", int'(got.hold), int'(want.hold));
        if (got.blink !== want.blink)
          flag_mismatch("blink_level", int'(got.blink), int'(want.blink));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles, %0d results pending",
               $realtime, quiet_cycles, expected_meters.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t plan[$];
    cfg_t      phase_cfg[PHASES];
    int        ph;
    int        n;

    for (int c = 0; c < NUM_CHANNELS; c++) begin
      peak_mem[c]  = '0;
      hold_mem[c]  = '0;
      timer_mem[c] = '0;
      blink_mem[c] = '0;
    end
    meter_cfg = '{hold_ticks: HOLD_TICKS_RST, blink_decay: BLINK_DECAY_RST,
                  recent_age_limit: RECENT_AGE_LIMIT_RST};

    // reset settings: full volume caps at 192, max age counts as silent
    plan.push_back(tick_row(5'd0, 1, 1, 8'd255, 31'd0, 1, 192, 192, 255));
    plan.push_back(tick_row(5'd0, 1, 1, 8'd255, AGE_INACTIVE - 31'd1));
    plan.push_back(tick_row(5'd1, 0, 0, 8'd0, AGE_INACTIVE, 1, 0, 0, 0));
    plan.push_back(tick_row(5'd2, 1, 1, 8'd1, AGE_INACTIVE, 1, 0, 0, 0));
    plan.push_back(tick_row(5'd3, 0, 1, 8'd100, 31'd5, 1, 0, 0, 0));
    plan.push_back(tick_row(5'd4, 1, 0, 8'd100, 31'd2, 1, 0, 0, 255));
    plan.push_back(tick_row(5'd5, 1, 1, 8'd64, 31'd10, 1, 192, 192, 0));
    plan.push_back(tick_row(5'd6, 1, 1, 8'd63, 31'd3, 1, 189, 189, 0));
    plan.push_back(tick_row(5'd7, 1, 1, 8'd1, 31'd1, 1, 3, 3, 255));
    // peak falls through zero to -1, then a silent level of 0 lifts it back
    plan.push_back(tick_row(5'd7, 1, 1, 8'd0, 31'd100));
    plan.push_back(tick_row(5'd7, 1, 1, 8'd0, 31'd100));
    plan.push_back(tick_row(5'd7, 1, 1, 8'd0, 31'd100));
    plan.push_back(tick_row(5'd31, 1, 1, 8'd255, AGE_INACTIVE - 31'd1, 1, 192, 192, 0));
    plan.push_back(tick_row(5'd31, 0, 1, 8'd255, 31'd7));
    // no hold time and a light that never fades
    plan.push_back(reg_row(REG_HOLD_TICKS, 8'd0));
    plan.push_back(reg_row(REG_BLINK_DECAY, 8'd0));
    plan.push_back(reg_row(REG_RECENT_AGE_LIMIT, 8'd255));
    plan.push_back(tick_row(5'd8, 1, 1, 8'd10, 31'd0, 1, 30, 30, 255));
    plan.push_back(tick_row(5'd8, 1, 1, 8'd0, 31'd1000));
    plan.push_back(tick_row(5'd8, 1, 1, 8'd0, 31'd1000));
    plan.push_back(tick_row(5'd9, 1, 1, 8'd2, 31'd1000, 1, 6, 6, 0));
    plan.push_back(tick_row(5'd9, 1, 1, 8'd0, 31'd254));
    plan.push_back(tick_row(5'd9, 1, 1, 8'd0, 31'd300));

    phase_cfg[0] = '{8'd30, 8'd8, 8'd3};
    phase_cfg[1] = '{8'd255, 8'd255, 8'd255};
    phase_cfg[2] = '{8'd0, 8'd1, 8'd0};
    phase_cfg[3] = '{8'd1, 8'd255, 8'd1};
    phase_cfg[4] = '{8'($urandom_range(255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(255))};
    phase_cfg[5] = '{8'd0, 8'd0, 8'd10};
    phase_cfg[6] = '{8'($urandom_range(255)), 8'($urandom_range(1, 255)),
                     8'($urandom_range(255))};
    phase_cfg[7] = '{8'd255, 8'd1, 8'd255};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, plan[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_reg(REG_HOLD_TICKS, phase_cfg[ph].hold_ticks);
      write_reg(REG_BLINK_DECAY, phase_cfg[ph].blink_decay);
      write_reg(REG_RECENT_AGE_LIMIT, phase_cfg[ph].recent_age_limit);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 11; sink_stall_pct = 11; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_tick(random_tick(), 1'b0, '0);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_meters.size() != 0)
      flag_mismatch("results never delivered", expected_meters.size(), 0);

    $display("covered %0d meter ticks and %0d results over %0d register writes,",
             ticks_sent, meters_seen, reg_writes);
    $display("with free flow, source gaps, sink stalls and both mixed; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
